// ----- rtl/stereo_crossfade_mixer_top_assert.svh -----
// ----------------------------------------------------------------------------
// stereo_crossfade_mixer_top_assert.svh
// assertion macros for the stereo crossfade mixer, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef STEREO_CROSSFADE_MIXER_TOP_ASSERT_SVH
`define STEREO_CROSSFADE_MIXER_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off during reset
`define SCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crossfade mixer check failed");
// next-cycle implication, clocked on clk, off during reset
`define SCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crossfade mixer check failed");
`else
`define SCM_ASSERT_IMP(lbl, ante, cons)
`define SCM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// types, codes, widths and the quarter-wave sine table of the crossfade mixer
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

  // field and port widths
  localparam int SAMPLE_W   = 24;
  localparam int POS_W      = 17;
  localparam int GAIN_W     = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 17;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 72;

  // sine table geometry
  localparam int SINE_DEPTH = 1024;
  localparam int TAB_AW     = 11;

  localparam logic [POS_W-1:0]  FULL_POS = 17'h10000;
  localparam logic [POS_W-1:0]  HALF_POS = 17'h08000;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE  = 3'd0,
    KIND_FADE_B  = 3'd1,
    KIND_FADE_A  = 3'd2,
    KIND_SET_POS = 3'd3,
    KIND_SNAP_A  = 3'd4,
    KIND_SNAP_B  = 3'd5,
    KIND_PAUSE   = 3'd6,
    KIND_RESUME  = 3'd7
  } kind_t;

  // fade modes
  typedef enum logic [1:0] {
    MODE_A  = 2'd0,
    MODE_AB = 2'd1,
    MODE_BA = 2'd2,
    MODE_B  = 2'd3
  } fade_mode_t;

  // curve codes, anything else is plain sine/cosine
  localparam logic [2:0] CURVE_SQRT   = 3'd1;
  localparam logic [2:0] CURVE_LINEAR = 3'd2;
  localparam logic [2:0] CURVE_PAN    = 3'd3;
  localparam logic [2:0] CURVE_SMOOTH = 3'd4;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MANUAL = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CURVE  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_STEP   = 2'd3;

  localparam longint Q30_ONE = 64'sd1 <<< 30;

  typedef logic [GAIN_W-1:0] sine_tab_t [0:SINE_DEPTH];

  // odd taylor polynomial of sin(pi/2 x) in q30, rounded to the gain format
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    longint            x;
    longint            y;
    longint            p;
    longint unsigned   r;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x = (longint'(k) <<< 30) / SINE_DEPTH;
      y = (x * x) / Q30_ONE;
      p = -64'sd3864;
      p = 64'sd172272 + (y * p) / Q30_ONE;
      p = -64'sd5026996 + (y * p) / Q30_ONE;
      p = 64'sd85569306 + (y * p) / Q30_ONE;
      p = -64'sd693598668 + (y * p) / Q30_ONE;
      p = 64'sd1686629713 + (y * p) / Q30_ONE;
      p = (x * p) / Q30_ONE;
      if (p < 0) p = 0;
      r = (unsigned'(p) + (64'd1 << (29 - GAIN_FRAC))) >> (30 - GAIN_FRAC);
      if (r > 64'(GAIN_ONE)) r = 64'(GAIN_ONE);
      tab[k] = GAIN_W'(r);
    end
    tab[SINE_DEPTH] = GAIN_ONE;
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ----- rtl/stereo_crossfade_mixer_top.sv -----
// ----------------------------------------------------------------------------
// stereo_crossfade_mixer_top
// ramped crossfade of two stereo sources with five gain curves
// ----------------------------------------------------------------------------
//  channel  dir  handshake              contents
//  in_      in   in_tvalid/in_tready    kind in tuser, samples and position
//  out_     out  out_tvalid/out_tready  mixed samples, position, fade flag
//  cfg_     in   cfg_wr_en              register index and write data
//
//  commands complete in the idle state, a disabled sample goes straight to output
//  an enabled sample's time depends on its curve, set by the sine rom read,
//  the 17 step root loop and the single multiplier shared by smoothstep,
//  interpolation and mix
//  reset is synchronous and active low; rst_n restores the register defaults
//  in_tready is low while a request is in work; a finished result waits in
//  the output register and only a second result stalls behind it
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_crossfade_mixer_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [scm_pkg::CFG_AW-1:0]        cfg_addr,
  input  wire logic [scm_pkg::CFG_DW-1:0]        cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // left_a, right_a, left_b, right_b, new_position, zero pad
  input  wire logic [scm_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind
  input  wire logic [scm_pkg::KIND_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_left, out_right, position_now, crossfading, zero pad
  output logic [scm_pkg::OUT_DATA_W-1:0]         out_tdata
);

  import scm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SM1, S_SM2, S_SM3, S_GSEL, S_LO, S_HI, S_INT, S_SUM, S_SQ, S_MIX, S_DONE
  } state_t;

  typedef enum logic [1:0] {GOP_VAL, GOP_SIN, GOP_SQRT} gop_t;

  // configuration
  logic                  enable_r;
  logic                  manual_r;
  logic [2:0]            curve_r;
  logic [POS_W-1:0]      step_r;

  // fade state
  fade_mode_t            mode_r;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      target_r;
  logic                  paused_r;

  // sequencer and datapath
  state_t                state_r;
  logic signed [SAMPLE_W-1:0] la_r, ra_r, lb_r, rb_r;
  logic signed [SAMPLE_W-1:0] res_l_r, res_r_r;
  logic [POS_W-1:0]      t_r;
  logic [POS_W-1:0]      s_r;
  logic                  gsel_r;
  logic                  xfade_r;
  logic [GAIN_W-1:0]     ga_r, gb_r;
  logic [POS_W-1:0]      p_r;
  logic [GAIN_W-1:0]     lo_r;
  logic [GAIN_W-1:0]     rom_q_r;
  logic signed [53:0]    prod_r;
  logic signed [43:0]    acc_r;
  logic [34:0]           sq_v_r, sq_res_r, sq_bit_r;
  logic [2:0]            mix_cnt_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // input fields
  kind_t                      in_kind;
  logic signed [SAMPLE_W-1:0] in_la, in_ra, in_lb, in_rb;
  logic [POS_W-1:0]           in_newpos;
  logic                       in_acc;

  assign in_kind   = kind_t'(in_tuser);
  assign in_la     = in_tdata[23:0];
  assign in_ra     = in_tdata[47:24];
  assign in_lb     = in_tdata[71:48];
  assign in_rb     = in_tdata[95:72];
  assign in_newpos = in_tdata[112:96];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // position ramp for a sample request
  logic [POS_W:0]        up_sum;
  logic signed [POS_W+1:0] dn_sum;
  logic [POS_W-1:0]      adv_pos;
  fade_mode_t            adv_mode;

  always_comb begin
    up_sum   = {1'b0, pos_r} + {1'b0, step_r};
    dn_sum   = $signed({2'b00, pos_r}) - $signed({2'b00, step_r});
    adv_pos  = pos_r;
    adv_mode = mode_r;
    if (enable_r && !manual_r && !paused_r) begin
      if (mode_r == MODE_AB) begin
        if (up_sum >= {1'b0, target_r}) begin
          adv_pos  = FULL_POS;
          adv_mode = MODE_B;
        end else if (up_sum > {1'b0, FULL_POS}) begin
          adv_pos = FULL_POS;
        end else begin
          adv_pos = up_sum[POS_W-1:0];
        end
      end else if (mode_r == MODE_BA) begin
        if (dn_sum <= $signed({2'b00, target_r})) begin
          adv_pos  = '0;
          adv_mode = MODE_A;
        end else if (dn_sum < 0) begin
          adv_pos = '0;
        end else begin
          adv_pos = dn_sum[POS_W-1:0];
        end
      end
    end
  end

  // clamp for the set position request
  logic [POS_W-1:0] set_pos;
  assign set_pos = (in_newpos > FULL_POS) ? FULL_POS : in_newpos;

  // gain operation for the current side
  gop_t                  g_op;
  logic [POS_W-1:0]      g_arg;
  logic [POS_W-1:0]      inv_t;
  logic signed [19:0]    phi;
  logic signed [19:0]    mag;
  logic signed [19:0]    pan_tmp;

  always_comb begin
    inv_t   = FULL_POS - t_r;
    phi     = $signed({2'b00, t_r, 1'b0}) - 20'sd32768;
    mag     = (phi < 0) ? -phi : phi;
    pan_tmp = '0;
    g_op    = GOP_SIN;
    g_arg   = gsel_r ? s_r : (FULL_POS - s_r);
    case (curve_r)
      CURVE_SQRT: begin
        g_op  = GOP_SQRT;
        g_arg = gsel_r ? t_r : inv_t;
      end
      CURVE_LINEAR: begin
        g_op  = GOP_VAL;
        g_arg = gsel_r ? t_r : inv_t;
      end
      CURVE_PAN: begin
        if (!gsel_r) begin
          if (phi < 0) begin
            g_op  = GOP_VAL;
            g_arg = '0;
          end else if (phi <= 20'sd65536) begin
            g_arg = phi[POS_W-1:0];
          end else begin
            pan_tmp = 20'sd131072 - phi;
            g_arg   = pan_tmp[POS_W-1:0];
          end
        end else begin
          if (mag <= 20'sd65536) begin
            pan_tmp = 20'sd65536 - mag;
            g_arg   = pan_tmp[POS_W-1:0];
          end else begin
            g_op  = GOP_VAL;
            g_arg = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // sine rom addressing, second read clamped at the last entry
  logic [TAB_AW-1:0] tab_idx;
  logic [TAB_AW-1:0] rom_addr;
  assign tab_idx  = p_r[POS_W-1:6];
  always_comb begin
    rom_addr = tab_idx;
    if (state_r == S_HI && tab_idx != TAB_AW'(SINE_DEPTH)) rom_addr = tab_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    rom_q_r <= SINE_TAB[rom_addr];
  end

  // shared multiplier
  logic signed [34:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [53:0] mul_p;
  logic [GAIN_W-1:0]  interp_diff;
  logic [POS_W:0]     smooth_k;

  always_comb begin
    interp_diff = (rom_q_r > lo_r) ? rom_q_r - lo_r : '0;
    smooth_k    = 18'd196608 - {t_r, 1'b0};
    mul_a = 35'(la_r);
    mul_b = $signed({2'b00, ga_r});
    case (state_r)
      S_SM1: begin
        mul_a = $signed({18'd0, t_r});
        mul_b = $signed({2'b00, t_r});
      end
      S_SM2: begin
        mul_a = $signed({2'b00, prod_r[32:0]});
        mul_b = $signed({1'b0, smooth_k});
      end
      S_INT: begin
        mul_a = $signed({18'd0, interp_diff});
        mul_b = $signed({3'b000, p_r[5:0], 10'd0});
      end
      S_MIX: begin
        case (mix_cnt_r)
          3'd1: begin
            mul_a = 35'(lb_r);
            mul_b = $signed({2'b00, gb_r});
          end
          3'd2: begin
            mul_a = 35'(ra_r);
            mul_b = $signed({2'b00, ga_r});
          end
          3'd3: begin
            mul_a = 35'(rb_r);
            mul_b = $signed({2'b00, gb_r});
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // round half up, floor shift, saturate
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [43:0] a,
    input logic signed [43:0] b
  );
    logic signed [43:0] sum;
    logic signed [43:0] sh;
    sum = a + b + 44'sd32768;
    sh  = sum >>> GAIN_FRAC;
    if (sh > 44'sd8388607) return 24'sh7FFFFF;
    if (sh < -44'sd8388608) return 24'sh800000;
    return sh[SAMPLE_W-1:0];
  endfunction

  // smoothstep result, clamped to full
  logic [POS_W-1:0] smooth_s;
  assign smooth_s = (prod_r[50:32] > {2'b00, FULL_POS}) ? FULL_POS : prod_r[48:32];

  // sqrt step
  logic [34:0] sq_trial;
  assign sq_trial = sq_res_r + sq_bit_r;

  // interpolated sine value
  logic [GAIN_W:0] sin_val;
  assign sin_val = {1'b0, lo_r} + {1'b0, prod_r[32:16]};

  // gain produced this cycle
  logic              g_done;
  logic [GAIN_W-1:0] g_val;
  always_comb begin
    g_done = 1'b0;
    g_val  = g_arg;
    case (state_r)
      S_GSEL: g_done = (g_op == GOP_VAL);
      S_SUM: begin
        g_done = 1'b1;
        g_val  = sin_val[GAIN_W-1:0];
      end
      S_SQ: begin
        g_done = (sq_bit_r == '0);
        g_val  = sq_res_r[GAIN_W-1:0];
      end
      default: ;
    endcase
  end

  // sequencer, fade state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      manual_r    <= 1'b0;
      curve_r     <= '0;
      step_r      <= 17'd30;
      mode_r      <= MODE_A;
      pos_r       <= '0;
      target_r    <= '0;
      paused_r    <= 1'b0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ENABLE: enable_r <= cfg_wdata[0];
          REG_MANUAL: manual_r <= cfg_wdata[0];
          REG_CURVE:  curve_r  <= cfg_wdata[2:0];
          REG_STEP:   step_r   <= cfg_wdata;
          default: ;
        endcase
      end

      // result taken, a new one in S_DONE reloads it below
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_kind)
              KIND_SAMPLE: begin
                pos_r   <= adv_pos;
                mode_r  <= adv_mode;
                t_r     <= adv_pos;
                s_r     <= adv_pos;
                xfade_r <= (adv_mode == MODE_AB || adv_mode == MODE_BA) && !paused_r;
                la_r    <= in_la;
                ra_r    <= in_ra;
                lb_r    <= in_lb;
                rb_r    <= in_rb;
                res_l_r <= in_la;
                res_r_r <= in_ra;
                gsel_r  <= 1'b0;
                if (!enable_r) state_r <= S_DONE;
                else if (curve_r == CURVE_SMOOTH) state_r <= S_SM1;
                else state_r <= S_GSEL;
              end
              KIND_FADE_B, KIND_FADE_A: begin
                if (enable_r) begin
                  target_r <= (in_kind == KIND_FADE_B) ? FULL_POS : '0;
                  mode_r   <= (in_kind == KIND_FADE_B) ? MODE_AB : MODE_BA;
                  paused_r <= 1'b0;
                end
              end
              KIND_SET_POS: begin
                pos_r    <= set_pos;
                target_r <= set_pos;
                if (set_pos == '0) mode_r <= MODE_A;
                else if (set_pos == FULL_POS) mode_r <= MODE_B;
                else if (set_pos > HALF_POS) mode_r <= MODE_AB;
                else mode_r <= MODE_BA;
              end
              KIND_SNAP_A, KIND_SNAP_B: begin
                pos_r    <= (in_kind == KIND_SNAP_B) ? FULL_POS : '0;
                target_r <= (in_kind == KIND_SNAP_B) ? FULL_POS : '0;
                mode_r   <= (in_kind == KIND_SNAP_B) ? MODE_B : MODE_A;
                paused_r <= 1'b0;
              end
              KIND_PAUSE:  paused_r <= 1'b1;
              default:     paused_r <= 1'b0;
            endcase
          end
        end

        // smoothstep: t*t, then times (3 - 2t)
        S_SM1: begin
          prod_r  <= mul_p;
          state_r <= S_SM2;
        end
        S_SM2: begin
          prod_r  <= mul_p;
          state_r <= S_SM3;
        end
        S_SM3: begin
          s_r     <= smooth_s;
          state_r <= S_GSEL;
        end

        // pick how the current gain is formed
        S_GSEL: begin
          if (g_op == GOP_SIN) begin
            p_r     <= g_arg;
            state_r <= S_LO;
          end else if (g_op == GOP_SQRT) begin
            sq_v_r   <= {2'b00, g_arg, 16'd0};
            sq_res_r <= '0;
            sq_bit_r <= 35'd1 << 32;
            state_r  <= S_SQ;
          end
        end

        // table interpolation
        S_LO: state_r <= S_HI;
        S_HI: begin
          lo_r    <= rom_q_r;
          state_r <= S_INT;
        end
        S_INT: begin
          prod_r  <= mul_p;
          state_r <= S_SUM;
        end
        S_SUM: ;

        // digit by digit square root
        S_SQ: begin
          if (sq_bit_r != '0) begin
            if (sq_v_r >= sq_trial) begin
              sq_v_r   <= sq_v_r - sq_trial;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end

        // four products, each accumulated in the cycle after it is formed
        S_MIX: begin
          if (mix_cnt_r <= 3'd3) prod_r <= mul_p;
          case (mix_cnt_r)
            3'd1: acc_r <= prod_r[43:0];
            3'd2: res_l_r <= round_sat(acc_r, prod_r[43:0]);
            3'd3: acc_r <= prod_r[43:0];
            3'd4: begin
              res_r_r <= round_sat(acc_r, prod_r[43:0]);
              state_r <= S_DONE;
            end
            default: ;
          endcase
          mix_cnt_r <= mix_cnt_r + 1'b1;
        end

        // hand over once the output register is free
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, xfade_r, t_r, res_r_r, res_l_r};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      // store a finished gain
      if (g_done) begin
        if (!gsel_r) begin
          ga_r    <= g_val;
          gsel_r  <= 1'b1;
          state_r <= S_GSEL;
        end else begin
          gb_r      <= g_val;
          mix_cnt_r <= '0;
          state_r   <= S_MIX;
        end
      end
    end
  end

  `include "stereo_crossfade_mixer_top_assert.svh"

  `SCM_ASSERT_IMP(a_pos_range, 1'b1, pos_r <= FULL_POS)
  `SCM_ASSERT_IMP(a_mode_b_end, mode_r == MODE_B, pos_r == FULL_POS)
  `SCM_ASSERT_IMP(a_mode_a_end, mode_r == MODE_A, pos_r == '0)
  `SCM_ASSERT_IMP(a_gain_range, state_r == S_MIX, ga_r <= GAIN_ONE && gb_r <= GAIN_ONE)
  `SCM_ASSERT_NXT(a_done_hold, state_r == S_DONE && out_valid_r && !out_tready, state_r == S_DONE && out_valid_r)

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// crossfade mixer testbench
// drives commands and samples through the stream ports, predicts each mixed
// sample from a local model of the fade state and gain curves, and checks
// every result in order; configuration changes only while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import scm_pkg::*;

  // mixed sample as seen on out_tdata
  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic [16:0] pos;
    logic        fading;
  } mix_result_t;

  class mix_scoreboard;
    logic [16:0] sine_rom [0:1024];
    bit          en;
    bit          manual;
    logic [2:0]  curve;
    logic [16:0] step;
    fade_mode_t  mode;
    logic [16:0] pos;
    logic [16:0] target;
    bit          paused;
    mix_result_t pending [$];
    int          errors;

    function new();
      longint x, y, p;
      longint unsigned r;
      for (int k = 0; k <= 1024; k++) begin
        x = (longint'(k) <<< 30) / 1024;
        y = (x * x) / (64'sd1 <<< 30);
        p = -64'sd3864;
        p = 64'sd172272 + (y * p) / (64'sd1 <<< 30);
        p = -64'sd5026996 + (y * p) / (64'sd1 <<< 30);
        p = 64'sd85569306 + (y * p) / (64'sd1 <<< 30);
        p = -64'sd693598668 + (y * p) / (64'sd1 <<< 30);
        p = 64'sd1686629713 + (y * p) / (64'sd1 <<< 30);
        p = (x * p) / (64'sd1 <<< 30);
        if (p < 0) p = 0;
        r = (unsigned'(p) + 64'd8192) >> 14;
        if (r > 65536) r = 65536;
        sine_rom[k] = r[16:0];
      end
      sine_rom[1024] = 17'h10000;
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      en = 1'b1; manual = 1'b0; curve = '0; step = 17'd30;
      mode = MODE_A; pos = '0; target = '0; paused = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        REG_ENABLE: en = val[0];
        REG_MANUAL: manual = val[0];
        REG_CURVE:  curve = val[2:0];
        default:    step = val;
      endcase
    endfunction

    // quarter-wave sine, q16 phase, linear interpolation
    function longint unsigned qsin(longint unsigned ph);
      longint unsigned prod, fr, lo, hi;
      int idx;
      if (ph > 65536) ph = 65536;
      prod = ph * 1024;
      idx = int'(prod >> 16);
      fr = prod & 16'hffff;
      if (idx >= 1024) return sine_rom[1024];
      lo = sine_rom[idx];
      hi = sine_rom[idx + 1];
      return lo + (((hi > lo ? hi - lo : 0) * fr) >> 16);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function void curve_gains(longint unsigned t, output longint unsigned ga,
                              output longint unsigned gb);
      longint phi, mag;
      longint unsigned s;
      if (curve == CURVE_SQRT) begin
        ga = root((65536 - t) << 16);
        gb = root(t << 16);
      end else if (curve == CURVE_LINEAR) begin
        ga = 65536 - t;
        gb = t;
      end else if (curve == CURVE_PAN) begin
        phi = 2 * longint'(t) - 32768;
        mag = phi < 0 ? -phi : phi;
        if (phi < 0) ga = 0;
        else if (phi <= 65536) ga = qsin(phi);
        else ga = qsin(131072 - phi);
        gb = (mag <= 65536) ? qsin(65536 - mag) : 0;
      end else begin
        s = t;
        if (curve == CURVE_SMOOTH) begin
          s = ((t * t) * (3 * 65536 - 2 * t)) >> 32;
          if (s > 65536) s = 65536;
        end
        ga = qsin(65536 - s);
        gb = qsin(s);
      end
    endfunction

    function logic [23:0] blend(logic signed [23:0] a, logic signed [23:0] b,
                                longint unsigned ga, longint unsigned gb);
      longint sum, r;
      sum = longint'(a) * longint'(ga) + longint'(b) * longint'(gb) + 32768;
      if (sum >= 0) r = sum >>> 16;
      else r = -((-sum + 65535) >>> 16);
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[23:0];
    endfunction

    function void ramp();
      longint p;
      if (mode == MODE_AB) begin
        p = longint'(pos) + longint'(step);
        if (p >= longint'(target)) begin p = 65536; mode = MODE_B; end
        pos = p > 65536 ? 17'h10000 : p[16:0];
      end else if (mode == MODE_BA) begin
        p = longint'(pos) - longint'(step);
        if (p <= longint'(target)) begin p = 0; mode = MODE_A; end
        pos = p < 0 ? 17'd0 : p[16:0];
      end
    endfunction

    // note one accepted request
    function void note_request(kind_t k, logic [119:0] d);
      mix_result_t r;
      longint unsigned ga, gb;
      logic [16:0] np;
      case (k)
        KIND_SAMPLE: begin
          if (en) begin
            if (!manual && !paused) ramp();
            curve_gains(pos, ga, gb);
            r.left = blend(d[23:0], d[71:48], ga, gb);
            r.right = blend(d[47:24], d[95:72], ga, gb);
          end else begin
            r.left = d[23:0];
            r.right = d[47:24];
          end
          r.pos = pos;
          r.fading = (mode == MODE_AB || mode == MODE_BA) && !paused;
          pending.push_back(r);
        end
        KIND_FADE_B, KIND_FADE_A: if (en) begin
          target = (k == KIND_FADE_B) ? 17'h10000 : 17'd0;
          mode = (k == KIND_FADE_B) ? MODE_AB : MODE_BA;
          paused = 0;
        end
        KIND_SET_POS: begin
          np = d[112:96];
          if (np > 17'h10000) np = 17'h10000;
          pos = np;
          target = np;
          if (np == 0) mode = MODE_A;
          else if (np == 17'h10000) mode = MODE_B;
          else mode = np > 17'h08000 ? MODE_AB : MODE_BA;
        end
        KIND_SNAP_A, KIND_SNAP_B: begin
          pos = (k == KIND_SNAP_B) ? 17'h10000 : 17'd0;
          target = pos;
          mode = (k == KIND_SNAP_B) ? MODE_B : MODE_A;
          paused = 0;
        end
        KIND_PAUSE: paused = 1;
        default: paused = 0;
      endcase
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [71:0] d);
      mix_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[23:0] !== e.left) begin
        $error("out_left expected %h got %h", e.left, d[23:0]); errors++;
      end
      if (d[47:24] !== e.right) begin
        $error("out_right expected %h got %h", e.right, d[47:24]); errors++;
      end
      if (d[64:48] !== e.pos) begin
        $error("position_now expected %h got %h", e.pos, d[64:48]); errors++;
      end
      if (d[65] !== e.fading) begin
        $error("crossfading expected %b got %b", e.fading, d[65]); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_wr_en = 0;
  logic [1:0]   cfg_addr = '0;
  logic [16:0]  cfg_wdata = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [71:0]  out_tdata;

  mix_scoreboard sb = new();
  longint cycles = 0;
  bit     hold_off = 0;
  bit     stall_mode = 0;

  stereo_crossfade_mixer_top dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: sample and check, stall on its own pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(negedge clk) begin
    if (hold_off) out_tready <= 0;
    else if (stall_mode) out_tready <= ($urandom_range(0, 3) == 0);
    else out_tready <= 1;
  end

  always begin
    repeat ($urandom_range(100, 400)) @(negedge clk);
    stall_mode = ~stall_mode;
  end

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  // drive one request, hold until accepted
  task automatic send(kind_t k, logic [119:0] d);
    in_tvalid <= 1;
    in_tuser <= k;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(k, d);
    @(negedge clk);
  endtask

  task automatic send_sample();
    send(KIND_SAMPLE, {24'd0, rand_sample(), rand_sample(), rand_sample(), rand_sample()});
  endtask

  task automatic send_random();
    logic [16:0] np;
    int r;
    r = $urandom_range(0, 99);
    np = ($urandom_range(0, 3) == 0) ? 17'($urandom) :
         17'($urandom_range(0, 65536));
    if (r < 70) send_sample();
    else send(kind_t'($urandom_range(1, 7)),
              {7'd0, np, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)});
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_wr_en <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.write_reg(idx, val);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, every command, each special case
    write_reg(REG_STEP, 17'd20000);
    send_sample();
    send(KIND_FADE_B, '0);
    repeat (2) send_sample();
    send(KIND_PAUSE, '0);
    send_sample();
    send(KIND_RESUME, '0);
    repeat (3) send_sample();
    send(KIND_FADE_A, '0);
    send_sample();
    send(KIND_SET_POS, {7'd0, 17'h1ffff, 96'd0});
    send_sample();
    send(KIND_SET_POS, {7'd0, 17'h0c000, 96'd0});
    send_sample();
    send(KIND_SET_POS, {7'd0, 17'h04000, 96'd0});
    send_sample();
    send(KIND_SNAP_B, '0);
    send(KIND_PAUSE, '0);
    send(KIND_SNAP_A, '0);
    send(KIND_SET_POS, '0);
    send(KIND_SAMPLE, {24'd0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff});
    drain();

    // phases over configurations, curves 0 to 7 including unused codes
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_CURVE, 17'(ph % 8));
      write_reg(REG_STEP, ph == 0 ? 17'd0 : ph == 1 ? 17'h10000 : ph == 2 ? 17'h1ffff :
                ph == 3 ? 17'd1 : 17'($urandom_range(1, 8000)));
      write_reg(REG_MANUAL, 17'(ph == 5));
      write_reg(REG_ENABLE, 17'(ph != 7));
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 5) == 0) begin
          in_tvalid <= 0;
          repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        if (ph == 4 && n == 10) hold_off = 1;
        if (ph == 4 && n == 40) hold_off = 0;
        send_random();
      end
      drain();
    end

    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // long receiver hold-off counted in cycles of its own
  always @(posedge clk) begin
    if (hold_off) begin
      repeat (300) @(posedge clk);
      hold_off = 0;
    end
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/scm_pkg.sv
rtl/stereo_crossfade_mixer_top.sv
sim/testbench.sv
